// ----- hw/rtl/ilt_pkg.sv -----
// Shared types, character codes and helper functions for the INI line tokenizer.
`timescale 1ns / 1ps

package ilt_pkg;

    // Default depth of the trailing-blank hold store
    localparam int unsigned BLANK_DEPTH_DEFAULT = 16;

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_BEL      = 8'h07;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_EQUALS   = 8'h3D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LOW_A    = 8'h61;
    localparam logic [7:0] CH_LOW_B    = 8'h62;
    localparam logic [7:0] CH_LOW_N    = 8'h6E;
    localparam logic [7:0] CH_LOW_R    = 8'h72;
    localparam logic [7:0] CH_LOW_T    = 8'h74;

    typedef enum logic [1:0] {
        K_KEY     = 2'd0,
        K_SECTION = 2'd1,
        K_VALUE   = 2'd2,
        K_RECORD  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        LT_OTHER   = 2'd0,
        LT_SECTION = 2'd1,
        LT_COMMENT = 2'd2,
        LT_ENTRY   = 2'd3
    } line_type_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_data;
    } text_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_char;
        line_type_t line_type;
        logic       parse_error;
        logic       name_valid;
        logic       last_of_run;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load;         // capture the accepted text byte
        logic load_zero;    // replace the byte with NUL for the end-of-data pass
        logic eval;         // run one parse step on the held byte
        logic rec;          // emit the line record and reset line state
        logic eod_pending;  // an end-of-data pass still follows this byte
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic flush;        // step only pops a held blank; repeat it
        logic eol;          // line ends with this byte; record follows
        logic emit;         // step produces a result word
    } dp_status_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CH_NUL) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic [7:0] unescape(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            CH_ZERO:  r = CH_NUL;
            CH_LOW_A: r = CH_BEL;
            CH_LOW_B: r = CH_BS;
            CH_LOW_T: r = CH_TAB;
            CH_LOW_R: r = CH_CR;
            CH_LOW_N: r = CH_LF;
            default:  r = c;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/ilt_dp.sv -----
// Datapath: parse state, blank hold store, byte register and result register.
`timescale 1ns / 1ps

module ilt_dp #(
    parameter int unsigned MAX_PENDING_BLANKS = ilt_pkg::BLANK_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ilt_pkg::text_t      text,
    input  ilt_pkg::dp_cmd_t    cmd,
    output ilt_pkg::dp_status_t st,
    output ilt_pkg::result_t    result
);
    import ilt_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_PENDING_BLANKS + 1);

    typedef enum logic [2:0] {
        PH_BEGIN   = 3'd0,
        PH_END     = 3'd1,
        PH_COMMENT = 3'd2,
        PH_SECTION = 3'd3,
        PH_KEY     = 3'd4,
        PH_EQUALS  = 3'd5,
        PH_VALUE   = 3'd6,
        PH_JUNK    = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_INSIDE = 2'd1,
        Q_DONE   = 2'd2
    } quote_t;

    phase_t     ph_reg, ph_next, ph_n;
    quote_t     qph_reg, qph_next, qph_n;
    logic       esc_reg, esc_next, esc_n;
    logic       vst_reg, vst_next, vst_n;
    logic       vfin_reg, vfin_next, vfin_n;
    logic       err_reg, err_next, err_n;
    line_type_t lt_reg, lt_next, lt_n;
    logic [CNT_W-1:0] cnt_reg, cnt_next, wr_cnt;
    logic [MAX_PENDING_BLANKS-1:0] store_reg, store_next;
    logic [7:0] char_reg, char_next;
    result_t    res_reg, res_next;

    logic [7:0] c;
    logic       clear_cnt;
    logic       push_req;
    logic [7:0] push_val;
    logic       push_st;
    logic       pop;
    logic       flush;
    logic       eol_after;
    logic       d_emit;
    kind_t      d_kind;
    logic [7:0] d_char;
    logic       emit_any;
    logic       cnt_full;
    logic       nv;

    assign c        = char_reg;
    assign cnt_full = (cnt_reg == CNT_W'(MAX_PENDING_BLANKS));

    // Parse step decode
    always_comb
    begin
        ph_n      = ph_reg;
        qph_n     = qph_reg;
        esc_n     = esc_reg;
        vst_n     = vst_reg;
        vfin_n    = vfin_reg;
        err_n     = err_reg;
        lt_n      = lt_reg;
        clear_cnt = 1'b0;
        push_req  = 1'b0;
        push_val  = c;
        d_emit    = 1'b0;
        d_kind    = K_VALUE;
        d_char    = c;
        eol_after = is_eol(c);

        unique case (ph_reg)
            PH_BEGIN:
            begin
                if (c == CH_LBRACKET)
                begin
                    ph_n = PH_SECTION;
                    lt_n = LT_SECTION;
                end
                else if (is_blank(c))
                begin
                end
                else if (is_eol(c))
                begin
                    lt_n = LT_OTHER;
                end
                else if (c == CH_SEMI)
                begin
                    ph_n = PH_COMMENT;
                    lt_n = LT_COMMENT;
                end
                else
                begin
                    ph_n   = PH_KEY;
                    lt_n   = LT_ENTRY;
                    d_emit = 1'b1;
                    d_kind = K_KEY;
                end
            end
            PH_END:
            begin
                if (is_eol(c) || is_blank(c))
                begin
                end
                else if (c == CH_SEMI)
                begin
                    ph_n = PH_COMMENT;
                end
                else
                begin
                    // junk after the section name closes the line at once
                    err_n     = 1'b1;
                    eol_after = 1'b1;
                end
            end
            PH_SECTION:
            begin
                if (c == CH_RBRACKET)
                begin
                    ph_n = PH_END;
                end
                else if (!is_eol(c))
                begin
                    d_emit = 1'b1;
                    d_kind = K_SECTION;
                end
            end
            PH_KEY:
            begin
                if (is_blank(c))
                begin
                    ph_n = PH_EQUALS;
                end
                else if (c == CH_EQUALS)
                begin
                    ph_n = PH_VALUE;
                end
                else if (is_eol(c))
                begin
                    err_n = 1'b1;
                end
                else
                begin
                    d_emit = 1'b1;
                    d_kind = K_KEY;
                end
            end
            PH_EQUALS:
            begin
                if (is_blank(c))
                begin
                end
                else if (c == CH_EQUALS)
                begin
                    ph_n = PH_VALUE;
                end
                else
                begin
                    err_n = 1'b1;
                    ph_n  = PH_JUNK;
                end
            end
            PH_VALUE:
            begin
                if (!vst_reg && is_blank(c))
                begin
                end
                else
                begin
                    vst_n = 1'b1;
                    if (is_eol(c) || vfin_reg)
                    begin
                        // a dangling backslash stands for itself
                        if (esc_reg)
                        begin
                            push_req = 1'b1;
                            push_val = CH_BSLASH;
                        end
                        esc_n     = 1'b0;
                        clear_cnt = 1'b1;
                        ph_n      = PH_COMMENT;
                    end
                    else if (c == CH_SEMI && qph_reg != Q_INSIDE && !esc_reg)
                    begin
                        vfin_n    = 1'b1;
                        clear_cnt = 1'b1;
                        ph_n      = PH_COMMENT;
                    end
                    else if (c == CH_BSLASH && !esc_reg)
                    begin
                        esc_n = 1'b1;
                    end
                    else if (esc_reg)
                    begin
                        push_req = 1'b1;
                        push_val = unescape(c);
                        esc_n    = 1'b0;
                    end
                    else if (c == CH_QUOTE)
                    begin
                        if (qph_reg == Q_NONE)
                        begin
                            if (!vst_reg)
                            begin
                                qph_n = Q_INSIDE;
                            end
                            else
                            begin
                                err_n    = 1'b1;
                                push_req = 1'b1;
                            end
                        end
                        else if (qph_reg == Q_INSIDE)
                        begin
                            qph_n = Q_DONE;
                        end
                        else
                        begin
                            err_n = 1'b1;
                        end
                    end
                    else if (qph_reg != Q_DONE)
                    begin
                        push_req = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Resolve a value push against the blank hold store
    always_comb
    begin
        push_st = 1'b0;
        pop     = 1'b0;
        flush   = 1'b0;
        if (push_req && qph_reg == Q_NONE && is_blank(push_val))
        begin
            // full store: release the oldest blank to make room
            push_st = 1'b1;
            pop     = cnt_full;
        end
        else if (push_req && qph_reg == Q_NONE && cnt_reg != '0)
        begin
            flush = 1'b1;
            pop   = 1'b1;
        end
    end

    assign emit_any = pop || (push_req && !push_st) || d_emit;

    assign st.flush = flush;
    assign st.eol   = eol_after;
    assign st.emit  = emit_any;

    always_comb
    begin
        unique case (lt_reg)
            LT_SECTION: nv = (ph_reg == PH_END) || (ph_reg == PH_COMMENT);
            LT_ENTRY:   nv = (ph_reg != PH_KEY);
            default:    nv = 1'b0;
        endcase
    end

    // Result word
    always_comb
    begin
        res_next             = res_reg;
        res_next.line_type   = LT_OTHER;
        res_next.parse_error = 1'b0;
        res_next.name_valid  = 1'b0;
        if (cmd.rec)
        begin
            res_next.kind        = K_RECORD;
            res_next.out_char    = CH_NUL;
            res_next.line_type   = lt_reg;
            res_next.parse_error = err_reg;
            res_next.name_valid  = nv;
            res_next.last_of_run = 1'b1;
        end
        else if (pop)
        begin
            res_next.kind        = K_VALUE;
            res_next.out_char    = store_reg[0] ? CH_TAB : CH_SPACE;
            res_next.last_of_run = !flush && !eol_after && !cmd.eod_pending;
        end
        else if (push_req)
        begin
            res_next.kind        = K_VALUE;
            res_next.out_char    = push_val;
            res_next.last_of_run = !eol_after && !cmd.eod_pending;
        end
        else
        begin
            res_next.kind        = d_kind;
            res_next.out_char    = d_char;
            res_next.last_of_run = !eol_after && !cmd.eod_pending;
        end
    end

    // Blank store: oldest entry at bit 0, new entry written behind the last held one
    always_comb
    begin
        wr_cnt     = pop ? (cnt_reg - CNT_W'(1)) : cnt_reg;
        store_next = store_reg;
        if (cmd.eval && !cmd.rec)
        begin
            if (pop)
            begin
                store_next = store_reg >> 1;
            end
            for (int k = 0; k < MAX_PENDING_BLANKS; k++)
            begin
                if (push_st && CNT_W'(k) == wr_cnt)
                begin
                    store_next[k] = (push_val == CH_TAB);
                end
            end
        end
    end

    // State update
    always_comb
    begin
        ph_next   = ph_reg;
        qph_next  = qph_reg;
        esc_next  = esc_reg;
        vst_next  = vst_reg;
        vfin_next = vfin_reg;
        err_next  = err_reg;
        lt_next   = lt_reg;
        cnt_next  = cnt_reg;
        if (cmd.rec)
        begin
            ph_next   = PH_BEGIN;
            qph_next  = Q_NONE;
            esc_next  = 1'b0;
            vst_next  = 1'b0;
            vfin_next = 1'b0;
            err_next  = 1'b0;
            lt_next   = LT_OTHER;
            cnt_next  = '0;
        end
        else if (cmd.eval)
        begin
            cnt_next = cnt_reg - CNT_W'(pop) + CNT_W'(push_st);
            if (!flush)
            begin
                ph_next   = ph_n;
                qph_next  = qph_n;
                esc_next  = esc_n;
                vst_next  = vst_n;
                vfin_next = vfin_n;
                err_next  = err_n;
                lt_next   = lt_n;
                if (clear_cnt)
                begin
                    cnt_next = '0;
                end
            end
        end
    end

    always_comb
    begin
        priority if (cmd.load)
        begin
            char_next = text.text_byte;
        end
        else if (cmd.load_zero)
        begin
            char_next = CH_NUL;
        end
        else
        begin
            char_next = char_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= PH_BEGIN;
            qph_reg  <= Q_NONE;
            esc_reg  <= 1'b0;
            vst_reg  <= 1'b0;
            vfin_reg <= 1'b0;
            err_reg  <= 1'b0;
            lt_reg   <= LT_OTHER;
            cnt_reg  <= '0;
        end
        else
        begin
            ph_reg   <= ph_next;
            qph_reg  <= qph_next;
            esc_reg  <= esc_next;
            vst_reg  <= vst_next;
            vfin_reg <= vfin_next;
            err_reg  <= err_next;
            lt_reg   <= lt_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
        char_reg  <= char_next;
        if ((cmd.eval && emit_any) || cmd.rec)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_PENDING_BLANKS))
        else $error("blank count above store depth");

    a_quote_no_blanks: assert property (@(posedge clk) disable iff (!rst_n)
        qph_reg != Q_NONE |-> cnt_reg == '0)
        else $error("blanks held inside a quoted value");

    a_flush_in_value: assert property (@(posedge clk) disable iff (!rst_n)
        flush |-> ph_reg == PH_VALUE && cnt_reg != '0)
        else $error("blank flush outside a value");

endmodule

// ----- hw/rtl/ilt_ctrl.sv -----
// Controller: sequences parse steps, record emission and both handshakes.
`timescale 1ns / 1ps

module ilt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                text_valid,
    output logic                text_ready,
    input  logic                last_byte,
    output logic                result_valid,
    input  logic                result_ready,
    input  ilt_pkg::dp_status_t st,
    output ilt_pkg::dp_cmd_t    cmd
);
    import ilt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_REC
    } state_t;

    state_t state_reg, state_next;
    logic   eod_reg, eod_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   take_ok;

    assign out_free = !out_valid_reg || result_ready;

    always_comb
    begin
        cmd             = '0;
        cmd.eod_pending = eod_reg;
        state_next      = state_reg;
        eod_next        = eod_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        take_ok         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                take_ok = 1'b1;
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    cmd.eval = 1'b1;
                    if (st.emit)
                    begin
                        out_valid_next = 1'b1;
                    end
                    if (st.flush)
                    begin
                        // hold: same byte again after the pop
                    end
                    else if (st.eol)
                    begin
                        state_next = S_REC;
                        eod_next   = 1'b0;
                    end
                    else if (eod_reg)
                    begin
                        cmd.load_zero = 1'b1;
                        eod_next      = 1'b0;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        take_ok    = 1'b1;
                    end
                end
            end
            S_REC:
            begin
                if (out_free)
                begin
                    cmd.rec        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    take_ok        = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (take_ok && text_valid)
        begin
            cmd.load   = 1'b1;
            eod_next   = last_byte;
            state_next = S_EVAL;
        end
    end

    assign text_ready   = take_ok;
    assign result_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            eod_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            eod_reg       <= eod_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_rec_no_eod: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REC |-> !eod_reg)
        else $error("end-of-data pass pending after line record");

endmodule

// ----- hw/rtl/ini_line_tokenizer_top.sv -----
// Top level of the INI line tokenizer.
`timescale 1ns / 1ps

// Takes INI text one byte per input word and returns tagged key, section and
// value characters, then one line record per line. The next word is taken in
// the same cycle an ordinary byte's parse step finishes. A byte that ends a line
// is followed by a step for the record. Each blank released from the hold store
// (MAX_PENDING_BLANKS entries) before a later value character takes a step of its
// own, since the result register takes one word per cycle while the result port
// is not stalled. A byte flagged end_of_data on an open line adds a pass on a
// NUL byte, then the record. A stalled result port holds the parse step in place.

module ini_line_tokenizer_top #(
    parameter int unsigned MAX_PENDING_BLANKS = ilt_pkg::BLANK_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             text_valid,
    output logic             text_ready,
    input  ilt_pkg::text_t   text,
    output logic             result_valid,
    input  logic             result_ready,
    output ilt_pkg::result_t result
);
    import ilt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t st;

    ilt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_ready   (text_ready),
        .last_byte    (text.end_of_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .st           (st),
        .cmd          (cmd)
    );

    ilt_dp #(
        .MAX_PENDING_BLANKS (MAX_PENDING_BLANKS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .cmd    (cmd),
        .st     (st),
        .result (result)
    );

endmodule
